/* rtl/htrgb_pkg.sv */
// ----------------------------------------------------------------------------
// htrgb_pkg
// Shared constants and stage types for the hue/tone to RGB PWM converter.
// ----------------------------------------------------------------------------
`default_nettype none

package htrgb_pkg;

  // Field widths
  localparam int unsigned DutyW = 10;

  // Scale constants
  localparam logic [9:0]  FULL_SCALE = 10'd1000;
  localparam logic [9:0]  TONE_KNEE  = 10'd500;
  localparam logic [9:0]  WARM_GREEN = 10'd800;
  localparam logic [9:0]  WARM_BLUE  = 10'd400;

  // Reciprocal of 5: n / 5 == (n * RECIP5) >> RECIP5_SH for n < 4096
  localparam logic [11:0] RECIP5     = 12'd3277;
  localparam int unsigned RECIP5_SH  = 14;

  // Reciprocal of 1000: p / 1000 == (p * RECIP1K) >> RECIP1K_SH for p < 2**20
  localparam logic [20:0] RECIP1K    = 21'd1073742;
  localparam int unsigned RECIP1K_SH = 30;

  // Hue sector codes
  localparam logic [2:0] SEC_R_GUP   = 3'd0;
  localparam logic [2:0] SEC_RDN_G   = 3'd1;
  localparam logic [2:0] SEC_G_BUP   = 3'd2;
  localparam logic [2:0] SEC_GDN_B   = 3'd3;
  localparam logic [2:0] SEC_RUP_B   = 3'd4;
  localparam logic [2:0] SEC_R_BDN   = 3'd5;
  localparam logic [2:0] SEC_WRAP    = 3'd6;

  // Stage 1 payload: sector split and white-blend numerators
  typedef struct packed {
    logic        on;
    logic        white;
    logic        tone_low;
    logic [9:0]  bright;
    logic [2:0]  sector;
    logic [9:0]  up;
    logic [11:0] num_r;
    logic [11:0] num_g;
    logic [11:0] num_b;
  } s1_t;

  // Stage 2 payload: unscaled channel levels
  typedef struct packed {
    logic [9:0] bright;
    logic [9:0] lvl_r;
    logic [9:0] lvl_g;
    logic [9:0] lvl_b;
  } s2_t;

  // Stage 3 payload: level times brightness
  typedef struct packed {
    logic [19:0] prod_r;
    logic [19:0] prod_g;
    logic [19:0] prod_b;
  } s3_t;

  // Divide by 5 through the reciprocal
  function automatic logic [9:0] div5(input logic [11:0] n);
    logic [23:0] p;
    p = 24'(n) * 24'(RECIP5);
    return p[RECIP5_SH +: 10];
  endfunction

  // Divide by 1000 through the reciprocal and saturate at full scale
  function automatic logic [9:0] scale_sat(input logic [19:0] n);
    logic [40:0] p;
    logic [10:0] q;
    p = 41'(n) * 41'(RECIP1K);
    q = p[RECIP1K_SH +: 11];
    return (q > 11'(FULL_SCALE)) ? FULL_SCALE : q[9:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/hue_tone_to_rgb_pwm_core.sv */
// ----------------------------------------------------------------------------
// hue_tone_to_rgb_pwm_core
// Converts a lamp setting (on, brightness, hue, white tone) into three PWM
// duty values in thousandths.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_* carries one lamp setting per word; master channel m_*
//   carries the three duty values for it, one result word per input word.
//   Hue zero selects tunable white (two-segment blend over tone, knee at 500);
//   any other hue is split into six sectors. Each channel is scaled by
//   brightness / 1000 (truncated) and saturated at 1000. Lamp off or zero
//   brightness gives all-zero duties.
//   Pipeline: four register stages (sector split, channel levels, brightness
//   multiply, reciprocal divide with saturation); m_tvalid and the result
//   word are registered together in the last stage.
//   Throughput: one word per cycle while m_tready is high; each stage
//   holds one word and the per-stage valid bits form a stall chain.
//   Stall: when m_tready is low the output word holds, upstream stages fill
//   their bubbles, then s_tready drops. Nothing is lost or repeated.
//   Reset: rst clears every valid bit; the pipeline comes up empty.
// ----------------------------------------------------------------------------
`default_nettype none

module hue_tone_to_rgb_pwm_core
  import htrgb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Input words
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // lamp_on[0], brightness[10:1], hue[20:11],
                                      // white_tone[30:21], zero[31]
  // Result words
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata    // duty_red[9:0], duty_green[19:10],
                                      // duty_blue[29:20], zero[31:30]
);

  // Unpack input word
  logic       in_on;
  logic [9:0] in_bright;
  logic [9:0] in_hue;
  logic [9:0] in_tone;

  assign in_on     = s_tdata[0];
  assign in_bright = s_tdata[10:1];
  assign in_hue    = s_tdata[20:11];
  assign in_tone   = s_tdata[30:21];

  // Stage registers
  logic       v1, v2, v3;
  s1_t        s1, s1_next;
  s2_t        s2, s2_next;
  s3_t        s3, s3_next;
  logic [9:0] duty_r, duty_g, duty_b;

  // Stall chain: a stage loads when it is empty or its word moves on
  logic adv_out, adv3, adv2, adv1;

  assign adv_out  = !m_tvalid || m_tready;
  assign adv3     = !v3 || adv_out;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign s_tready = adv1;

  // Stage 1: split hue into sector and ramp position; form blend numerators
  logic [12:0] h;
  logic [12:0] base;
  logic [2:0]  sector;
  logic [9:0]  tdiff;

  always_comb begin
    h = (13'(in_hue) << 2) + (13'(in_hue) << 1);
    if (h >= 13'd6000) begin
      sector = SEC_WRAP;
      base   = 13'd6000;
    end else if (h >= 13'd5000) begin
      sector = SEC_R_BDN;
      base   = 13'd5000;
    end else if (h >= 13'd4000) begin
      sector = SEC_RUP_B;
      base   = 13'd4000;
    end else if (h >= 13'd3000) begin
      sector = SEC_GDN_B;
      base   = 13'd3000;
    end else if (h >= 13'd2000) begin
      sector = SEC_G_BUP;
      base   = 13'd2000;
    end else if (h >= 13'd1000) begin
      sector = SEC_RDN_G;
      base   = 13'd1000;
    end else begin
      sector = SEC_R_GUP;
      base   = 13'd0;
    end

    tdiff            = in_tone - TONE_KNEE;
    s1_next.on       = in_on;
    s1_next.white    = (in_hue == '0);
    s1_next.tone_low = (in_tone <= TONE_KNEE);
    s1_next.bright   = in_bright;
    s1_next.sector   = sector;
    s1_next.up       = 10'(h - base);
    if (s1_next.tone_low) begin
      // Warm segment: green rises 2/5, blue rises 6/5 of tone
      s1_next.num_r = '0;
      s1_next.num_g = 12'(in_tone) << 1;
      s1_next.num_b = (12'(in_tone) << 2) + (12'(in_tone) << 1);
    end else begin
      // Cool segment: red falls 6/5, green falls 1/5 of tone above the knee
      s1_next.num_r = (12'(tdiff) << 2) + (12'(tdiff) << 1);
      s1_next.num_g = 12'(tdiff);
      s1_next.num_b = '0;
    end
  end

  // Stage 2: channel levels from the sector ramp or the white blend
  logic [9:0] down;
  logic [9:0] q_r, q_g, q_b;

  always_comb begin
    down = FULL_SCALE - s1.up;
    q_r  = div5(s1.num_r);
    q_g  = div5(s1.num_g);
    q_b  = div5(s1.num_b);
    s2_next.bright = s1.bright;
    s2_next.lvl_r  = '0;
    s2_next.lvl_g  = '0;
    s2_next.lvl_b  = '0;
    if (s1.white) begin
      if (s1.tone_low) begin
        s2_next.lvl_r = FULL_SCALE;
        s2_next.lvl_g = WARM_GREEN + q_g;
        s2_next.lvl_b = WARM_BLUE + q_b;
      end else begin
        s2_next.lvl_r = FULL_SCALE - q_r;
        s2_next.lvl_g = FULL_SCALE - q_g;
        s2_next.lvl_b = FULL_SCALE;
      end
    end else begin
      case (s1.sector)
        SEC_R_GUP: begin
          s2_next.lvl_r = FULL_SCALE;
          s2_next.lvl_g = s1.up;
        end
        SEC_RDN_G: begin
          s2_next.lvl_r = down;
          s2_next.lvl_g = FULL_SCALE;
        end
        SEC_G_BUP: begin
          s2_next.lvl_g = FULL_SCALE;
          s2_next.lvl_b = s1.up;
        end
        SEC_GDN_B: begin
          s2_next.lvl_g = down;
          s2_next.lvl_b = FULL_SCALE;
        end
        SEC_RUP_B: begin
          s2_next.lvl_r = s1.up;
          s2_next.lvl_b = FULL_SCALE;
        end
        default: begin
          // Last sector, also taken by full-scale and out-of-range hues
          s2_next.lvl_r = FULL_SCALE;
          s2_next.lvl_b = down;
        end
      endcase
    end
    // Drop everything when the lamp is off
    if (!s1.on) begin
      s2_next.lvl_r = '0;
      s2_next.lvl_g = '0;
      s2_next.lvl_b = '0;
    end
  end

  // Stage 3: multiply each level by brightness
  always_comb begin
    s3_next.prod_r = 20'(s2.lvl_r) * 20'(s2.bright);
    s3_next.prod_g = 20'(s2.lvl_g) * 20'(s2.bright);
    s3_next.prod_b = 20'(s2.lvl_b) * 20'(s2.bright);
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (adv1)    v1       <= s_tvalid;
      if (adv2)    v2       <= v1;
      if (adv3)    v3       <= v2;
      if (adv_out) m_tvalid <= v3;
    end
  end

  // Advance payload; stage 4 divides by 1000 and saturates
  always_ff @(posedge clk) begin
    if (adv1) s1 <= s1_next;
    if (adv2) s2 <= s2_next;
    if (adv3) s3 <= s3_next;
    if (adv_out) begin
      duty_r <= scale_sat(s3.prod_r);
      duty_g <= scale_sat(s3.prod_g);
      duty_b <= scale_sat(s3.prod_b);
    end
  end

  assign m_tdata = {2'b00, duty_b, duty_g, duty_r};

endmodule

`default_nettype wire

/* tb/hue_tone_to_rgb_pwm_checker.sv */
// ----------------------------------------------------------------------------
// hue_tone_to_rgb_pwm_checker
// Watches both stream channels of the converter. It predicts the three duty
// values for every accepted setting and checks each result word against them
// in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hue_tone_to_rgb_pwm_checker
  import htrgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // lamp_on[0], brightness[10:1], hue[20:11],
                                 // white_tone[30:21], zero[31]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // duty_red[9:0], duty_green[19:10],
                                 // duty_blue[29:20], zero[31:30]
  output int          mismatch_count,
  output int          pending_count
);

  typedef struct packed {
    logic [DutyW-1:0] blue;
    logic [DutyW-1:0] green;
    logic [DutyW-1:0] red;
  } duty_set_t;

  duty_set_t expected_duties[$];
  int        errors = 0;

  assign mismatch_count = errors;
  assign pending_count  = expected_duties.size();

  // Scale a 0..1000 level by brightness in thousandths, truncate, clamp
  function automatic int unsigned dim_level(input int unsigned level,
                                            input logic [9:0] bright);
    int unsigned scaled;
    scaled = (level * bright) / 1000;
    return (scaled > 1000) ? 1000 : scaled;
  endfunction

  // Work out the three duties for one lamp setting
  function automatic duty_set_t predict_duties(input logic on,
                                               input logic [9:0] bright,
                                               input logic [9:0] hue,
                                               input logic [9:0] tone);
    int unsigned lvl_r, lvl_g, lvl_b, h6, up, down, cool;
    duty_set_t   d;
    lvl_r = 0;
    lvl_g = 0;
    lvl_b = 0;
    if (on && bright != 0) begin
      if (hue == 0) begin
        // tunable white: warm segment up to the knee, cool segment above it
        if (tone <= 500) begin
          lvl_r = 1000;
          lvl_g = 800 + (tone * 200) / 500;
          lvl_b = 400 + (tone * 600) / 500;
        end else begin
          cool  = tone - 500;
          lvl_r = 1000 - (cool * 600) / 500;
          lvl_g = 1000 - (cool * 100) / 500;
          lvl_b = 1000;
        end
      end else begin
        // six hue sectors; 1000 and above land in the last one
        h6   = hue * 6;
        up   = h6 % 1000;
        down = 1000 - up;
        case (h6 / 1000)
          0: begin
            lvl_r = 1000; lvl_g = up;   lvl_b = 0;
          end
          1: begin
            lvl_r = down; lvl_g = 1000; lvl_b = 0;
          end
          2: begin
            lvl_r = 0;    lvl_g = 1000; lvl_b = up;
          end
          3: begin
            lvl_r = 0;    lvl_g = down; lvl_b = 1000;
          end
          4: begin
            lvl_r = up;   lvl_g = 0;    lvl_b = 1000;
          end
          default: begin
            lvl_r = 1000; lvl_g = 0;    lvl_b = down;
          end
        endcase
      end
      lvl_r = dim_level(lvl_r, bright);
      lvl_g = dim_level(lvl_g, bright);
      lvl_b = dim_level(lvl_b, bright);
    end
    d.red   = lvl_r[DutyW-1:0];
    d.green = lvl_g[DutyW-1:0];
    d.blue  = lvl_b[DutyW-1:0];
    return d;
  endfunction

  // Check result words first, then queue the prediction for a new setting
  always @(posedge clk) begin : watch_channels
    duty_set_t want;
    duty_set_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.red   = m_tdata[9:0];
        got.green = m_tdata[19:10];
        got.blue  = m_tdata[29:20];
        if (expected_duties.size() == 0) begin
          $error("unexpected result word: red %0d green %0d blue %0d",
                 got.red, got.green, got.blue);
          errors++;
        end else begin
          want = expected_duties.pop_front();
          if (got.red !== want.red) begin
            $error("duty_red: expected %0d, got %0d", want.red, got.red);
            errors++;
          end
          if (got.green !== want.green) begin
            $error("duty_green: expected %0d, got %0d", want.green, got.green);
            errors++;
          end
          if (got.blue !== want.blue) begin
            $error("duty_blue: expected %0d, got %0d", want.blue, got.blue);
            errors++;
          end
          if (m_tdata[31:30] !== 2'b00) begin
            $error("zero pad: expected 0, got %0d", m_tdata[31:30]);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        expected_duties.push_back(predict_duties(s_tdata[0], s_tdata[10:1],
                                                 s_tdata[20:11], s_tdata[30:21]));
      end
    end
  end

endmodule

/* tb/hue_tone_to_rgb_pwm_core_tb.sv */
// ----------------------------------------------------------------------------
// hue_tone_to_rgb_pwm_core_tb
// Drives lamp settings into the converter: a directed sweep of the white
// blend, every hue sector and the out-of-range corners, then random settings
// under random source gaps and sink stalls, ending with a stretch at full
// rate. A checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hue_tone_to_rgb_pwm_core_tb;

  typedef struct packed {
    logic       on;
    logic [9:0] bright;
    logic [9:0] hue;
    logic [9:0] tone;
  } lamp_setting_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  int          mismatch_count;
  int          pending_count;
  bit          src_gaps_en = 1'b1;
  bit          sink_stalls_en = 1'b1;

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hue_tone_to_rgb_pwm_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  hue_tone_to_rgb_pwm_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  // Offer one setting, with an optional idle burst first; hold until taken
  task automatic send_setting(input logic on, input logic [9:0] bright,
                              input logic [9:0] hue, input logic [9:0] tone);
    if (src_gaps_en && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, tone, hue, bright, on};
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop valid and hold until every predicted word has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // Random setting biased toward lamp on, in-range values and the corners
  function automatic lamp_setting_t random_setting();
    lamp_setting_t s;
    s.on = ($urandom_range(0, 9) != 0);
    case ($urandom_range(0, 9))
      0:       s.bright = 10'd0;
      1:       s.bright = 10'd1000;
      2:       s.bright = 10'($urandom_range(1001, 1023));
      3:       s.bright = 10'($urandom);
      default: s.bright = 10'($urandom_range(1, 1000));
    endcase
    case ($urandom_range(0, 9))
      0, 1:    s.hue = 10'd0;
      2:       s.hue = 10'($urandom_range(1000, 1023));
      3:       s.hue = 10'($urandom);
      default: s.hue = 10'($urandom_range(1, 999));
    endcase
    case ($urandom_range(0, 7))
      0:       s.tone = 10'($urandom_range(499, 502));
      1:       s.tone = 10'($urandom_range(1000, 1023));
      default: s.tone = 10'($urandom);
    endcase
    return s;
  endfunction

  // Sink: stall in random bursts, with long ready stretches in between
  initial begin
    wait (!rst);
    @(posedge clk);
    forever begin
      if (sink_stalls_en && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 15)) @(posedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    lamp_setting_t s;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // lamp off or dark
    send_setting(1'b0, 10'd1000, 10'd0,    10'd500);
    send_setting(1'b0, 10'd1023, 10'd1023, 10'd1023);
    send_setting(1'b1, 10'd0,    10'd300,  10'd0);
    // white blend: ends, knee, cool past range
    send_setting(1'b1, 10'd1000, 10'd0,    10'd0);
    send_setting(1'b1, 10'd1000, 10'd0,    10'd500);
    send_setting(1'b1, 10'd1000, 10'd0,    10'd501);
    send_setting(1'b1, 10'd1000, 10'd0,    10'd1000);
    send_setting(1'b1, 10'd1000, 10'd0,    10'd1023);
    // every hue sector and its borders
    send_setting(1'b1, 10'd1000, 10'd1,    10'd0);
    send_setting(1'b1, 10'd1000, 10'd166,  10'd0);
    send_setting(1'b1, 10'd1000, 10'd167,  10'd0);
    send_setting(1'b1, 10'd1000, 10'd333,  10'd0);
    send_setting(1'b1, 10'd1000, 10'd334,  10'd0);
    send_setting(1'b1, 10'd1000, 10'd500,  10'd0);
    send_setting(1'b1, 10'd1000, 10'd667,  10'd0);
    send_setting(1'b1, 10'd1000, 10'd833,  10'd0);
    send_setting(1'b1, 10'd1000, 10'd999,  10'd0);
    // full-scale hue and hues past range
    send_setting(1'b1, 10'd1000, 10'd1000, 10'd0);
    send_setting(1'b1, 10'd1000, 10'd1023, 10'd1023);
    // brightness past range saturates; minimum brightness truncates
    send_setting(1'b1, 10'd1023, 10'd1,    10'd0);
    send_setting(1'b1, 10'd1023, 10'd0,    10'd250);
    send_setting(1'b1, 10'd1,    10'd0,    10'd0);
    send_setting(1'b1, 10'd999,  10'd511,  10'd682);
    drain_results();

    // random settings under gaps and stalls
    repeat (1200) begin
      s = random_setting();
      send_setting(s.on, s.bright, s.hue, s.tone);
    end
    drain_results();
    repeat (450) begin
      s = random_setting();
      send_setting(s.on, s.bright, s.hue, s.tone);
    end

    // full rate on both sides
    src_gaps_en    = 1'b0;
    sink_stalls_en = 1'b0;
    repeat (180) begin
      s = random_setting();
      send_setting(s.on, s.bright, s.hue, s.tone);
    end
    drain_results();
    repeat (8) @(posedge clk);

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Timeout
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* sim.f */
rtl/htrgb_pkg.sv
rtl/hue_tone_to_rgb_pwm_core.sv
tb/hue_tone_to_rgb_pwm_checker.sv
tb/hue_tone_to_rgb_pwm_core_tb.sv
